// ----- sv/mab_pkg.sv -----
// Shared types, constants and the rounded divide-by-255 helper for the alpha blender.
package mab_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned PixelW  = 32;
  localparam int unsigned ProdW   = 2 * ChanW;
  localparam logic [ChanW-1:0] ChanMax  = 8'd255;
  localparam logic [ProdW-1:0] RoundAdd = 16'd128;
  localparam int unsigned AlphaLsb = 24;

  typedef struct packed {
    logic [PixelW-1:0] dest_pixel;
    logic [ChanW-1:0]  coverage;
    logic              last_in;
  } mab_in_t;

  typedef struct packed {
    logic [PixelW-1:0] blended_pixel;
    logic              last_out;
  } mab_out_t;

  // Rounded t/255 for t up to 255*255; every intermediate fits in 16 bits.
  function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] t);
    logic [ProdW-1:0] u;
    logic [ProdW-1:0] w;
    u = t + RoundAdd;
    w = u + {8'd0, u[ProdW-1:ChanW]};
    return w[ProdW-1:ChanW];
  endfunction

endpackage

// ----- sv/masked_alpha_blend.sv -----
// Top level of the masked source-over alpha blender for ARGB8888 pixels.
//
// Usage: write the non-premultiplied source color through cfg_we_i/cfg_data_i
// while the block is idle. Then stream destination pixels with their mask
// coverage on the input channel (valid/ready); each item yields exactly one
// blended pixel on the output channel, in order, with last_out copied from
// last_in.
// Pipeline: the first of the four register stages loads at acceptance, and
// out_valid_o rises once the item loads into the stage 4 output register.
// Throughput: one item per cycle unless the output stalls; the four stages
// (coverage multiply, alpha divide, per-channel multiplies, per-channel sum
// and select) all advance together on a single enable.
// Stall: when the output holds an item that is not taken, the whole pipe
// freezes and in_ready_o drops in the same cycle; nothing is lost or
// repeated. A bubble advances normally, so ready stays high whenever the
// output register is empty or being drained.
// Reset: clears all stage valid bits and the source color to zero.
module masked_alpha_blend (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  mab_pkg::mab_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output mab_pkg::mab_out_t              out_data_o,
  input  logic                           cfg_we_i,
  input  logic [mab_pkg::PixelW-1:0]     cfg_data_i
);

  localparam int unsigned NumLanes = 4;
  localparam int unsigned CW = mab_pkg::ChanW;
  localparam int unsigned PW = mab_pkg::PixelW;

  logic [PW-1:0] src_q;
  logic [CW-1:0] src_a;
  logic          en;

  // Stage 1: coverage product and shortcut flags.
  logic                       v1_q;
  logic [PW-1:0]              dst1_q;
  logic                       last1_q, bd1_q, bs1_q;
  logic [mab_pkg::ProdW-1:0]  p1_q;

  // Stage 2: effective alpha and its complement.
  logic          v2_q;
  logic [PW-1:0] dst2_q;
  logic          last2_q, bd2_q, bs2_q;
  logic [CW-1:0] ea2_q, ia2_q;

  // Stage 3: products sit inside the lanes.
  logic          v3_q;
  logic [PW-1:0] dst3_q;
  logic          last3_q, bd3_q, bs3_q;

  // Stage 4: output register.
  logic              v4_q;
  mab_pkg::mab_out_t out_q, out_d;

  logic [CW-1:0] lane_out [NumLanes];
  logic [PW-1:0] blend_pix;

  assign src_a = src_q[mab_pkg::AlphaLsb +: CW];

  // Advance the whole pipe unless a finished item waits at the output.
  assign en         = !v4_q || out_ready_i;
  assign in_ready_o = en;

  // Hold the source color; the user must write it only while idle, as the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= '0;
    end else if (cfg_we_i) begin
      src_q <= cfg_data_i;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Stage 1
      dst1_q  <= in_data_i.dest_pixel;
      last1_q <= in_data_i.last_in;
      p1_q    <= mab_pkg::ProdW'(src_a) * mab_pkg::ProdW'(in_data_i.coverage);
      bd1_q   <= (in_data_i.coverage == '0) || (src_a == '0);
      bs1_q   <= (in_data_i.coverage == mab_pkg::ChanMax) && (src_a == mab_pkg::ChanMax);
      // Stage 2
      dst2_q  <= dst1_q;
      last2_q <= last1_q;
      bd2_q   <= bd1_q;
      bs2_q   <= bs1_q;
      ea2_q   <= mab_pkg::div255(p1_q);
      ia2_q   <= mab_pkg::ChanMax - mab_pkg::div255(p1_q);
      // Stage 3
      dst3_q  <= dst2_q;
      last3_q <= last2_q;
      bd3_q   <= bd2_q;
      bs3_q   <= bs2_q;
      // Stage 4
      out_q   <= out_d;
    end
  end

  // Color lanes blend the source channel; the alpha lane uses 255 in place
  // of the source, since div255(255 * ea) equals ea.
  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    logic [CW-1:0] lane_src;
    if (g == NumLanes - 1) begin : g_alpha
      assign lane_src = mab_pkg::ChanMax;
    end else begin : g_color
      assign lane_src = src_q[g*CW +: CW];
    end
    mab_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .src_i  (lane_src),
      .dst_i  (dst2_q[g*CW +: CW]),
      .ea_i   (ea2_q),
      .ia_i   (ia2_q),
      .chan_o (lane_out[g])
    );
    assign blend_pix[g*CW +: CW] = lane_out[g];
  end

  // Pick pass-through, opaque source, or the blended pixel.
  always_comb begin
    out_d.last_out = last3_q;
    if (bd3_q) begin
      out_d.blended_pixel = dst3_q;
    end else if (bs3_q) begin
      out_d.blended_pixel = src_q;
    end else begin
      out_d.blended_pixel = blend_pix;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

  // An accepted item shows up as valid in the first stage.
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted item missing from stage 1");

  // A stall freezes the valid bit of every stage before the output register.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(v1_q) && $stable(v2_q) && $stable(v3_q)))
    else $error("pipeline moved during stall");

  // Stage 3 contents reach the output when the pipe advances.
  a_stage3_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v3_q) |=> out_valid_o)
    else $error("stage 3 item dropped");

  // Effective alpha and its complement always add to full scale.
  a_alpha_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> ({1'b0, ea2_q} + {1'b0, ia2_q} == {1'b0, mab_pkg::ChanMax}))
    else $error("alpha complement mismatch");

endmodule

// ----- sv/mab_lane.sv -----
// One channel lane: register both products, then sum the two rounded quotients.
module mab_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [mab_pkg::ChanW-1:0]     src_i,
  input  logic [mab_pkg::ChanW-1:0]     dst_i,
  input  logic [mab_pkg::ChanW-1:0]     ea_i,
  input  logic [mab_pkg::ChanW-1:0]     ia_i,
  output logic [mab_pkg::ChanW-1:0]     chan_o
);

  logic [mab_pkg::ProdW-1:0] prod_s_q, prod_s_d;
  logic [mab_pkg::ProdW-1:0] prod_d_q, prod_d_d;
  logic [mab_pkg::ChanW:0]   sum;

  assign prod_s_d = mab_pkg::ProdW'(src_i) * mab_pkg::ProdW'(ea_i);
  assign prod_d_d = mab_pkg::ProdW'(dst_i) * mab_pkg::ProdW'(ia_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_s_q <= prod_s_d;
      prod_d_q <= prod_d_d;
    end
  end

  // The two terms never exceed 255 together; keep the low byte.
  assign sum = {1'b0, mab_pkg::div255(prod_s_q)} + {1'b0, mab_pkg::div255(prod_d_q)};
  assign chan_o = sum[mab_pkg::ChanW-1:0];

endmodule
